// ===== rtl/nfa_word_acceptance_top_macros.svh =====
// assertion macros for the nfa word acceptance block
`ifndef NFA_WORD_ACCEPTANCE_TOP_MACROS_SVH
`define NFA_WORD_ACCEPTANCE_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define NFA_WA_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("nfa_word_acceptance assertion failed");

// next-cycle implication, disabled during reset
`define NFA_WA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("nfa_word_acceptance assertion failed");

`endif

// ===== rtl/nfa_wa_pkg.sv =====
// package with shared constants of the nfa word acceptance block
package nfa_wa_pkg;

   localparam int NUM_STATES_DEF  = 32;
   localparam int SYMBOL_BITS_DEF = 8;

   localparam int MASK_W     = 32;
   localparam int FROM_W     = 5;
   localparam int SYM_W      = 8;
   localparam int KIND_W     = 2;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SYMBOL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_END    = 2'd2;

   localparam logic REG_INITIAL = 1'b0;
   localparam logic REG_FINAL   = 1'b1;

endpackage

// ===== rtl/nfa_wa_csr.sv =====
// configuration registers: initial and final state masks
module nfa_wa_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [nfa_wa_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [nfa_wa_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [nfa_wa_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                               csr_pready,
   output logic [nfa_wa_pkg::MASK_W-1:0]      initial_states,
   output logic [nfa_wa_pkg::MASK_W-1:0]      final_states
);
   import nfa_wa_pkg::*;

   logic              wr_en;
   logic              reg_sel;
   logic [MASK_W-1:0] init_ff;
   logic [MASK_W-1:0] init_in;
   logic [MASK_W-1:0] final_ff;
   logic [MASK_W-1:0] final_in;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      init_in  = init_ff;
      final_in = final_ff;
      if (wr_en) begin
         if (reg_sel == REG_INITIAL) begin
            init_in = csr_pwdata;
         end else begin
            final_in = csr_pwdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff  <= '0;
         final_ff <= '0;
      end else begin
         init_ff  <= init_in;
         final_ff <= final_in;
      end
   end

   assign csr_prdata     = (reg_sel == REG_INITIAL) ? init_ff : final_ff;
   assign initial_states = init_ff;
   assign final_states   = final_ff;

endmodule

// ===== rtl/nfa_wa_engine.sv =====
// transition table memory and subset simulation sequencer
module nfa_wa_engine #(
   parameter int NUM_STATES  = nfa_wa_pkg::NUM_STATES_DEF,
   parameter int SYMBOL_BITS = nfa_wa_pkg::SYMBOL_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [nfa_wa_pkg::MASK_W-1:0]    initial_states,
   input  logic [nfa_wa_pkg::MASK_W-1:0]    final_states,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [nfa_wa_pkg::KIND_W-1:0]    req_kind,
   input  logic [nfa_wa_pkg::FROM_W-1:0]    req_from_state,
   input  logic [nfa_wa_pkg::SYM_W-1:0]     req_symbol,
   input  logic [nfa_wa_pkg::MASK_W-1:0]    req_target_mask,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_accepted
);
   import nfa_wa_pkg::*;

   localparam int ASW   = (NUM_STATES < MASK_W) ? NUM_STATES : MASK_W;
   localparam int SW    = $clog2(ASW);
   localparam int AW    = SW + SYMBOL_BITS;
   localparam int DEPTH = ASW << SYMBOL_BITS;
   localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);
   localparam logic [SW-1:0] IDX_LAST = SW'(ASW - 1);

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_SCAN, ST_LAST} state_type;

   logic [ASW-1:0] mem [DEPTH];
   logic [ASW-1:0] rdata_ff;
   logic           mem_we;
   logic [AW-1:0]  mem_waddr;
   logic [ASW-1:0] mem_wdata;
   logic [AW-1:0]  mem_raddr;

   state_type        state_ff, state_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic [SW-1:0]    idx_ff, idx_in;
   logic [SYMBOL_BITS-1:0] sym_ff, sym_in;
   logic [ASW-1:0]   act_ff, act_in;
   logic [ASW-1:0]   nxt_ff, nxt_in;
   logic             in_word_ff, in_word_in;
   logic             rd_sel_ff, rd_sel_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_acc_ff, rsp_acc_in;

   logic             accept;
   logic             from_ok;
   logic [ASW-1:0]   init_m;
   logic [ASW-1:0]   final_m;

   assign init_m  = initial_states[ASW-1:0];
   assign final_m = final_states[ASW-1:0];
   assign from_ok = (32'(req_from_state) < 32'(ASW));

   assign req_ready = (state_ff == ST_IDLE) &&
                      ((req_kind != KIND_END) || !rsp_valid_ff || rsp_ready);
   assign accept    = req_valid & req_ready;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = clr_ff;
      mem_wdata = '0;
      mem_raddr = {idx_ff, sym_ff};
      if (state_ff == ST_CLEAR) begin
         mem_we = 1'b1;
      end else if (accept && (req_kind == KIND_WRITE) && from_ok) begin
         mem_we    = 1'b1;
         mem_waddr = {req_from_state[SW-1:0], req_symbol[SYMBOL_BITS-1:0]};
         mem_wdata = req_target_mask[ASW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      idx_in       = idx_ff;
      sym_in       = sym_ff;
      act_in       = act_ff;
      nxt_in       = nxt_ff;
      in_word_in   = in_word_ff;
      rd_sel_in    = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_acc_in   = rsp_acc_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_SYMBOL: begin
                     sym_in   = req_symbol[SYMBOL_BITS-1:0];
                     idx_in   = '0;
                     nxt_in   = '0;
                     state_in = ST_SCAN;
                     if (!in_word_ff) begin
                        act_in = init_m;
                     end
                  end
                  KIND_END: begin
                     rsp_valid_in = 1'b1;
                     rsp_acc_in   = |((in_word_ff ? act_ff : init_m) & final_m);
                     act_in       = '0;
                     in_word_in   = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            rd_sel_in = act_ff[idx_ff];
            idx_in    = idx_ff + SW'(1);
            if (rd_sel_ff) begin
               nxt_in = nxt_ff | rdata_ff;
            end
            if (idx_ff == IDX_LAST) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            act_in     = rd_sel_ff ? (nxt_ff | rdata_ff) : nxt_ff;
            in_word_in = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         idx_ff       <= '0;
         act_ff       <= '0;
         in_word_ff   <= 1'b0;
         rd_sel_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         idx_ff       <= idx_in;
         sym_ff       <= sym_in;
         act_ff       <= act_in;
         nxt_ff       <= nxt_in;
         in_word_ff   <= in_word_in;
         rd_sel_ff    <= rd_sel_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_acc_ff   <= rsp_acc_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_accepted = rsp_acc_ff;

endmodule

// ===== rtl/nfa_word_acceptance_top.sv =====
// top level of the nfa word acceptance block
//
// req channel carries one item per handshake: tuser holds the kind, tdata the
// source state, symbol and target mask. a table write stores the target mask
// of one (state, symbol) entry, a symbol item advances the active state set,
// an end item returns one rsp item whose bit 0 says whether the word is accepted.
// a table write or an end item is handled without leaving the idle state. for a
// symbol item the sequencer reads one table row per cycle from the table memory,
// one per state below min(NUM_STATES, 32), and ORs the rows of the active states.
// the end result appears on rsp in the cycle after its item is accepted and waits
// in an output register; while it waits, table writes and symbols are still
// taken, and only a further end item stalls until the result is taken.
// after reset the table memory is cleared one entry per cycle, all
// min(NUM_STATES, 32) << SYMBOL_BITS entries (8192 by default); req_tready is low
// during that pass, csr writes are taken at any time.
// csr registers: initial_states at 0x0, final_states at 0x4.
module nfa_word_acceptance_top #(
   parameter int NUM_STATES  = nfa_wa_pkg::NUM_STATES_DEF,
   parameter int SYMBOL_BITS = nfa_wa_pkg::SYMBOL_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // from_state[4:0], symbol[12:5], target_mask[44:13], zero fill
   input  logic [nfa_wa_pkg::REQ_DATA_W-1:0]  req_tdata,
   // kind[1:0]
   input  logic [nfa_wa_pkg::KIND_W-1:0]      req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // accepted[0], zero fill
   output logic [nfa_wa_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [nfa_wa_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [nfa_wa_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [nfa_wa_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                               csr_pready
);
   import nfa_wa_pkg::*;

   logic [MASK_W-1:0] initial_states;
   logic [MASK_W-1:0] final_states;
   logic              accepted;

   nfa_wa_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .initial_states (initial_states),
      .final_states   (final_states)
   );

   nfa_wa_engine #(
      .NUM_STATES  (NUM_STATES),
      .SYMBOL_BITS (SYMBOL_BITS)
   ) u_engine (
      .clock           (clock),
      .reset           (reset),
      .initial_states  (initial_states),
      .final_states    (final_states),
      .req_valid       (req_tvalid),
      .req_ready       (req_tready),
      .req_kind        (req_tuser),
      .req_from_state  (req_tdata[FROM_W-1:0]),
      .req_symbol      (req_tdata[FROM_W+SYM_W-1:FROM_W]),
      .req_target_mask (req_tdata[FROM_W+SYM_W+MASK_W-1:FROM_W+SYM_W]),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_accepted    (accepted)
   );

   assign rsp_tdata = {(RSP_DATA_W-1)'(0), accepted};

endmodule

// ===== rtl/nfa_wa_checker.sv =====
// port-level assertion checker for the nfa word acceptance block, with its bind
`include "nfa_word_acceptance_top_macros.svh"

module nfa_wa_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [nfa_wa_pkg::KIND_W-1:0]      req_tuser,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [nfa_wa_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import nfa_wa_pkg::*;

   logic in_acc;
   logic sym_acc;
   logic end_acc;

   assign in_acc  = req_tvalid & req_tready;
   assign sym_acc = in_acc & (req_tuser == KIND_SYMBOL);
   assign end_acc = in_acc & (req_tuser == KIND_END);

   `NFA_WA_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `NFA_WA_ASSERT_SAME(a_clear_after_reset, $fell(reset), !req_tready)
   `NFA_WA_ASSERT_NEXT(a_symbol_busy, sym_acc, !req_tready)
   `NFA_WA_ASSERT_SAME(a_rsp_from_end, $rose(rsp_tvalid), $past(end_acc))

endmodule

bind nfa_word_acceptance_top nfa_wa_checker u_nfa_wa_checker (.*);
